@@ sv/cwnm_pkg.sv @@
// Shared constants for the centered nonzero-mean smoothing block.
package cwnm_pkg;

   // default sizing of the block
   localparam int MAX_GAP_DEF     = 32;
   localparam int SAMPLE_BITS_DEF = 16;

   // fixed field widths
   localparam int GAP_W    = 6;
   localparam int COV_W    = 16;
   localparam int SMOOTH_W = 16;
   localparam int POS_W    = 32;
   localparam int RSP_W    = SMOOTH_W + POS_W;

   // gap register value after reset
   localparam logic [GAP_W-1:0] GAP_RESET = 6'd2;

endpackage

@@ sv/cwnm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module cwnm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 33
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/centered_window_nonzero_mean.sv @@
// Top level of the centered moving average over the nonzero coverage samples.
//
// Each request carries one coverage sample and a block-end flag. The result for
// position p is the truncated mean of the nonzero samples from floor(g/2)
// positions back (clipped at the block start) to ceil(g/2) positions ahead
// (clipped at the block end), or 0 when none is nonzero; g is the gap register,
// saturated to MAX_GAP. Results trail the requests by ceil(g/2) positions and a
// request with tlast set flushes all pending results, the final one with tlast.
// Requests are taken one at a time. A request that releases no result passes
// through the check state alone. For each result it releases, the block reads
// the window of W (at most g + 1) entries from the history RAM, one entry a cycle
// through its single read port, and forms the mean in a bit-serial divider of
// SW = SAMPLE_BITS + clog2(MAX_GAP + 2) bits (22 by default). A finished result
// waits in the output register while the block goes on with the next result or
// the next request.
module centered_window_nonzero_mean #(
   parameter int MAX_GAP     = cwnm_pkg::MAX_GAP_DEF,
   parameter int SAMPLE_BITS = cwnm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // gap register write
   input  logic                        csr_wr_en,
   input  logic [cwnm_pkg::GAP_W-1:0]  csr_wr_data,
   // request channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [cwnm_pkg::COV_W-1:0]  req_tdata,   // [15:0] coverage_sample
   input  logic                        req_tlast,   // block_end
   // result channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [cwnm_pkg::RSP_W-1:0]  rsp_tdata,   // [15:0] smoothed_coverage,
                                                    // [47:16] position
   output logic                        rsp_tlast    // last_of_block
);

   localparam int DEPTH = MAX_GAP + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = $clog2(DEPTH + 1);
   localparam int CW    = $clog2(MAX_GAP + 2);
   localparam int SW    = SAMPLE_BITS + CW;
   localparam int DW    = $clog2(SW + 1);
   localparam int GW    = cwnm_pkg::GAP_W;
   localparam int POSW  = cwnm_pkg::POS_W;
   localparam int MW    = cwnm_pkg::SMOOTH_W;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_READ  = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [GW-1:0]    gap_ff, gap_in;
   logic [AW-1:0]    newest_ff, newest_in;
   logic [POSW-1:0]  pos_ff, pos_in;
   logic [PW-1:0]    pending_ff, pending_in;
   logic [POSW-1:0]  item_n_ff, item_n_in;
   logic             item_end_ff, item_end_in;
   logic [AW-1:0]    rd_idx_ff, rd_idx_in;
   logic [CW-1:0]    rd_left_ff, rd_left_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [SW-1:0]    sum_ff, sum_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [POSW-1:0]  win_pos_ff, win_pos_in;
   logic             win_last_ff, win_last_in;
   logic [SW-1:0]    div_q_ff, div_q_in;
   logic [CW-1:0]    div_rem_ff, div_rem_in;
   logic [DW-1:0]    div_step_ff, div_step_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [MW-1:0]    rsp_mean_ff, rsp_mean_in;
   logic [POSW-1:0]  rsp_pos_ff, rsp_pos_in;
   logic             rsp_last_ff, rsp_last_in;

   logic                   accept;
   logic [GW-1:0]          gap_eff;
   logic [GW-1:0]          back_w;
   logic [GW-1:0]          ahead_w;
   logic [AW-1:0]          nxt_newest;
   logic                   emit_go;
   logic [PW-1:0]          pend_age;
   logic [POSW-1:0]        win_p;
   logic [GW-1:0]          back_clip;
   logic [PW-1:0]          ahead_clip;
   logic [AW-1:0]          age_start;
   logic [AW-1:0]          start_idx;
   logic [CW-1:0]          rd_count;
   logic                   rd_en;
   logic [SAMPLE_BITS-1:0] rd_data;
   logic [CW:0]            div_trial;
   logic                   div_ge;
   logic                   out_free;

   // sample history ring
   cwnm_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (nxt_newest),
      .wr_data (SAMPLE_BITS'(req_tdata)),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   // saturate the gap and split it into back and ahead reach
   always_comb begin
      gap_eff = (32'(gap_ff) > MAX_GAP) ? GW'(MAX_GAP) : gap_ff;
      back_w  = gap_eff >> 1;
      ahead_w = GW'(({1'b0, gap_eff} + (GW+1)'(1)) >> 1);
   end

   // window geometry of the oldest pending position
   always_comb begin
      pend_age   = pending_ff - PW'(1);
      win_p      = item_n_ff - POSW'(pend_age);
      back_clip  = (win_p < POSW'(back_w)) ? GW'(win_p) : back_w;
      ahead_clip = (32'(ahead_w) < 32'(pend_age)) ? PW'(ahead_w) : pend_age;
      age_start  = AW'(pend_age - ahead_clip);
      if (newest_ff >= age_start) begin
         start_idx = newest_ff - age_start;
      end else begin
         start_idx = AW'(32'(newest_ff) + DEPTH - 32'(age_start));
      end
      rd_count = CW'(32'(ahead_clip) + 32'(back_clip) + 1);
      if (item_end_ff) begin
         emit_go = (pending_ff != '0);
      end else begin
         emit_go = (32'(pending_ff) > 32'(ahead_w));
      end
   end

   assign accept     = req_tvalid && req_tready;
   assign nxt_newest = (newest_ff == AW'(DEPTH - 1)) ? '0 : newest_ff + AW'(1);
   assign rd_en      = (state_ff == ST_READ) && (rd_left_ff != '0);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign div_trial  = {div_rem_ff, div_q_ff[SW-1]};
   assign div_ge     = (div_trial >= {1'b0, cnt_ff});

   // sequencer: take request, walk each window, divide, hand off result
   always_comb begin
      state_in     = state_ff;
      gap_in       = csr_wr_en ? csr_wr_data : gap_ff;
      newest_in    = newest_ff;
      pos_in       = pos_ff;
      pending_in   = pending_ff;
      item_n_in    = item_n_ff;
      item_end_in  = item_end_ff;
      rd_idx_in    = rd_idx_ff;
      rd_left_in   = rd_left_ff;
      rd_pend_in   = rd_en;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      win_pos_in   = win_pos_ff;
      win_last_in  = win_last_ff;
      div_q_in     = div_q_ff;
      div_rem_in   = div_rem_ff;
      div_step_in  = div_step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_mean_in  = rsp_mean_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            // store the sample and advance the block position
            if (accept) begin
               newest_in   = nxt_newest;
               item_n_in   = pos_ff;
               item_end_in = req_tlast;
               pos_in      = req_tlast ? '0 : pos_ff + POSW'(1);
               if (pending_ff != PW'(DEPTH)) begin
                  pending_in = pending_ff + PW'(1);
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // open the window of the oldest pending position, or go idle
            if (emit_go) begin
               rd_idx_in   = start_idx;
               rd_left_in  = rd_count;
               sum_in      = '0;
               cnt_in      = '0;
               win_pos_in  = win_p;
               win_last_in = item_end_ff && (pending_ff == PW'(1));
               state_in    = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            // step back through the ring, accumulate nonzero samples
            if (rd_en) begin
               rd_idx_in  = (rd_idx_ff == '0) ? AW'(DEPTH - 1) : rd_idx_ff - AW'(1);
               rd_left_in = rd_left_ff - CW'(1);
            end
            if (rd_pend_ff && (rd_data != '0)) begin
               sum_in = sum_ff + SW'(rd_data);
               cnt_in = cnt_ff + CW'(1);
            end
            if ((rd_left_ff == '0) && !rd_pend_ff) begin
               div_q_in    = sum_ff;
               div_rem_in  = '0;
               div_step_in = DW'(SW);
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit a cycle
            if (div_step_ff != '0) begin
               div_rem_in  = div_ge ? CW'(div_trial - {1'b0, cnt_ff}) : CW'(div_trial);
               div_q_in    = {div_q_ff[SW-2:0], div_ge};
               div_step_in = div_step_ff - DW'(1);
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // load the output register once it is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = (cnt_ff == '0) ? '0 : MW'(div_q_ff);
               rsp_pos_in   = win_pos_ff;
               rsp_last_in  = win_last_ff;
               pending_in   = pending_ff - PW'(1);
               state_in     = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gap_ff       <= cwnm_pkg::GAP_RESET;
         newest_ff    <= '0;
         pos_ff       <= '0;
         pending_ff   <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gap_ff       <= gap_in;
         newest_ff    <= newest_in;
         pos_ff       <= pos_in;
         pending_ff   <= pending_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_n_ff   <= item_n_in;
      item_end_ff <= item_end_in;
      rd_idx_ff   <= rd_idx_in;
      rd_left_ff  <= rd_left_in;
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
      win_pos_ff  <= win_pos_in;
      win_last_ff <= win_last_in;
      div_q_ff    <= div_q_in;
      div_rem_ff  <= div_rem_in;
      div_step_ff <= div_step_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_pos_ff, rsp_mean_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ sv/cwnm_checker.sv @@
// Port-level checks for the centered nonzero-mean smoothing block, with its bind.
module cwnm_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [cwnm_pkg::RSP_W-1:0] rsp_tdata,
   input logic                       rsp_tlast
);

   // a stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // one request at a time: ready drops right after an accepted request
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // reset leaves no result and takes requests
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

   // a result can only appear while the block is busy with a request
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid ##1 rsp_tvalid |-> !req_tready)
      else $error("result raised while idle");

endmodule

bind centered_window_nonzero_mean cwnm_checker u_checker (.*);
